@@ hdl/dds_serial_command_sequencer_macros.svh @@
// Assertion macros for the serial command sequencer.
// Needs signals clk and rst in the scope where a macro is used.
`ifndef DDS_SERIAL_COMMAND_SEQUENCER_MACROS_SVH
`define DDS_SERIAL_COMMAND_SEQUENCER_MACROS_SVH

// Property checked on every edge outside reset.
`define DSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition on one edge implies a condition on the next edge.
`define DSC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/dsc_pkg.sv @@
// Shared constants and types for the serial command sequencer.
// No dependencies; used by every module of the block.
package dsc_pkg;

  localparam int unsigned CHANNELS_DEF = 2;

  localparam int unsigned MCLK_W  = 27;
  localparam int unsigned FREQ_W  = 32;
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned WORD_W  = 16;

  localparam logic [MCLK_W-1:0] MCLK_RESET = 27'd25000000;

  // Shared divider: dividend, divisor and quotient widths
  localparam int unsigned DIV_NW = 54;
  localparam int unsigned DIV_DW = 28;
  localparam int unsigned DIV_QW = 28;

  // Action codes
  localparam logic [3:0] ACT_INIT      = 4'd0;
  localparam logic [3:0] ACT_RESET     = 4'd1;
  localparam logic [3:0] ACT_START     = 4'd2;
  localparam logic [3:0] ACT_WAVEFORM  = 4'd3;
  localparam logic [3:0] ACT_SET_FREQ  = 4'd4;
  localparam logic [3:0] ACT_SEL_FREQ  = 4'd5;
  localparam logic [3:0] ACT_SET_PHASE = 4'd6;
  localparam logic [3:0] ACT_SEL_PHASE = 4'd7;
  localparam logic [3:0] ACT_SLEEP     = 4'd8;
  localparam logic [3:0] ACT_STOP      = 4'd9;
  localparam logic [3:0] ACT_SET_WAVE  = 4'd10;

  localparam logic [1:0] WAVE_SINE = 2'd0;
  localparam logic [1:0] WAVE_TRI  = 2'd1;

  // Control word bits and register address bases
  localparam logic [WORD_W-1:0] CW_B28      = 16'h2000;
  localparam logic [WORD_W-1:0] CW_HLB      = 16'h1000;
  localparam logic [WORD_W-1:0] CW_FSEL     = 16'h0800;
  localparam logic [WORD_W-1:0] CW_PSEL     = 16'h0400;
  localparam logic [WORD_W-1:0] CW_RESET    = 16'h0100;
  localparam logic [WORD_W-1:0] CW_SLEEP    = 16'h00C0;
  localparam logic [WORD_W-1:0] CW_OPBITEN  = 16'h0020;
  localparam logic [WORD_W-1:0] CW_MODE     = 16'h0002;
  localparam logic [WORD_W-1:0] CW_INIT     = 16'h2100;
  localparam logic [WORD_W-1:0] BASE_FREQ0  = 16'h4000;
  localparam logic [WORD_W-1:0] BASE_FREQ1  = 16'h8000;
  localparam logic [WORD_W-1:0] BASE_PHASE0 = 16'hC000;
  localparam logic [WORD_W-1:0] BASE_PHASE1 = 16'hE000;

  // Phase scaling: word = (p * 8192 + 36000) / 72000
  localparam logic [PHASE_W-1:0] PHASE_WRAP = 16'd36000;
  localparam logic [28:0]        PHASE_BIAS = 29'd36000;
  localparam logic [DIV_DW-1:0]  PHASE_DIV  = 28'd72000;

  typedef struct packed {
    logic              chip_select;
    logic [WORD_W-1:0] spi_word;
    logic              word_valid;
    logic              status;
    logic              last;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

endpackage

@@ hdl/dsc_divider.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Depends on dsc_pkg; the caller guarantees the quotient fits DIV_QW bits.
module dsc_divider import dsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  output logic              busy,
  output logic [DIV_QW-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DIV_QW + 1);

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dvs;
  logic [DIV_QW-1:0] acc;
  logic [CNT_W-1:0]  cnt;
  logic [DIV_DW:0]   trial;

  assign trial    = {rem, acc[DIV_QW-1]} - {1'b0, dvs};
  assign busy     = (cnt != '0);
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= CNT_W'(DIV_QW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // Upper dividend bits are already below the divisor, so start the
  // remainder with them and shift the low part through.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= DIV_DW'(req.dividend[DIV_NW-1:DIV_QW]);
      acc <= req.dividend[DIV_QW-1:0];
      dvs <= req.divisor;
    end else if (busy) begin
      if (!trial[DIV_DW]) begin
        rem <= trial[DIV_DW-1:0];
      end else begin
        rem <= {rem[DIV_DW-2:0], acc[DIV_QW-1]};
      end
      acc <= {acc[DIV_QW-2:0], ~trial[DIV_DW]};
    end
  end

endmodule

@@ hdl/dsc_ctrl.sv @@
// Command sequencer: control word shadows, ready flags and word emission.
// Depends on dsc_pkg; drives the shared divider and the result register.
module dsc_ctrl import dsc_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         action,
  input  logic               channel,
  input  logic [1:0]         reg_select,
  input  logic [FREQ_W-1:0]  frequency_q8,
  input  logic [PHASE_W-1:0] phase_centideg,
  input  logic [1:0]         waveform,
  input  logic               sleep_enable,
  input  logic [MCLK_W-1:0]  mclk,
  output div_req_t           div_req,
  input  logic               div_busy,
  input  logic [DIV_QW-1:0]  div_quot,
  output logic               res_valid,
  output res_t               res,
  input  logic               res_ready
);

  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [2:0]  PC_LAST = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_TX_INIT, S_EXEC, S_TX_CW, S_TX_FCW,
    S_TX_FLO, S_TX_FHI, S_TX_PH, S_TX_NOP, S_ERR
  } state_t;

  typedef enum logic [3:0] {
    OP_INIT, OP_RST_ON, OP_RST_OFF, OP_WAVE, OP_FREQ,
    OP_FSEL, OP_PHASE, OP_PSEL, OP_SLEEP, OP_STOP
  } op_t;

  state_t              state;
  op_t                 cur_op;
  logic [3:0]          act_q;
  logic                ch_q;
  logic [1:0]          reg_q;
  logic [FREQ_W-1:0]   fq_q;
  logic [PHASE_W-1:0]  ph_q;
  logic [1:0]          wf_q;
  logic                sl_q;
  logic [2:0]          pc;
  logic [CHANNELS-1:0] ready;
  logic [WORD_W-1:0]   shadow [CHANNELS];

  logic [CH_W-1:0]     ch_idx;
  logic [WORD_W-1:0]   cw;
  logic [WORD_W-1:0]   cw_new;
  logic [PHASE_W-1:0]  ph_red;
  logic [1:0]          reg_eff;
  logic                is_wave;
  logic                is_last;
  logic                ch_bad;
  logic                cmd_bad;
  logic                freq_bad;
  logic                op_fail;
  logic                take;
  logic [DIV_NW-1:0]   freq_num;
  logic [28:0]         phase_num;
  logic [WORD_W-1:0]   base_f;
  logic [WORD_W-1:0]   base_p;

  assign in_stall = (state != S_IDLE);
  assign ph_red   = (phase_centideg >= PHASE_WRAP) ? phase_centideg - PHASE_WRAP
                                                   : phase_centideg;
  assign ch_idx   = CH_W'(ch_q);
  assign cw       = shadow[ch_idx];
  assign is_wave  = (act_q == ACT_SET_WAVE);
  assign is_last  = !is_wave || (pc == PC_LAST);
  assign reg_eff  = is_wave ? 2'd0 : reg_q;
  assign ch_bad   = ({31'd0, ch_q} >= 32'(CHANNELS));
  assign cmd_bad  = ch_bad || (act_q > ACT_SET_WAVE);
  assign freq_bad = (mclk == '0) || ({2'b00, fq_q} > {mclk, 7'd0}) || reg_eff[1];
  assign base_f   = reg_eff[0] ? BASE_FREQ1 : BASE_FREQ0;
  assign base_p   = reg_eff[0] ? BASE_PHASE1 : BASE_PHASE0;
  assign freq_num  = {1'b0, fq_q, 21'd0} + {27'd0, mclk};
  assign phase_num = {ph_q[12:0] == ph_q[12:0] ? ph_q : ph_q, 13'd0} + PHASE_BIAS;
  assign take     = res_valid && res_ready;

  // Map the command and its step counter to one operation
  always_comb begin
    unique case (act_q)
      ACT_INIT:      cur_op = OP_INIT;
      ACT_RESET:     cur_op = OP_RST_ON;
      ACT_START:     cur_op = OP_RST_OFF;
      ACT_WAVEFORM:  cur_op = OP_WAVE;
      ACT_SET_FREQ:  cur_op = OP_FREQ;
      ACT_SEL_FREQ:  cur_op = OP_FSEL;
      ACT_SET_PHASE: cur_op = OP_PHASE;
      ACT_SEL_PHASE: cur_op = OP_PSEL;
      ACT_SLEEP:     cur_op = OP_SLEEP;
      ACT_SET_WAVE: begin
        case (pc)
          3'd0:    cur_op = OP_FREQ;
          3'd1:    cur_op = OP_PHASE;
          3'd2:    cur_op = OP_FSEL;
          3'd3:    cur_op = OP_PSEL;
          3'd4:    cur_op = OP_WAVE;
          default: cur_op = OP_RST_OFF;
        endcase
      end
      default:       cur_op = OP_STOP;
    endcase
  end

  // New control word and failure of the current operation
  always_comb begin
    cw_new  = cw;
    op_fail = 1'b0;
    unique case (cur_op)
      OP_INIT:    cw_new = CW_INIT;
      OP_RST_ON:  cw_new = cw | CW_RESET;
      OP_STOP:    cw_new = cw | CW_RESET;
      OP_RST_OFF: cw_new = cw & ~CW_RESET;
      OP_WAVE: begin
        cw_new = cw & ~(CW_OPBITEN | CW_MODE);
        if (wf_q == WAVE_TRI) begin
          cw_new = cw_new | CW_MODE;
        end else if (wf_q != WAVE_SINE) begin
          op_fail = 1'b1;
        end
      end
      OP_FREQ: begin
        op_fail = freq_bad;
        if (!freq_bad) begin
          cw_new = (cw | CW_B28) & ~CW_HLB;
        end
      end
      OP_FSEL: begin
        op_fail = reg_eff[1];
        if (!reg_eff[1]) begin
          cw_new = reg_eff[0] ? (cw | CW_FSEL) : (cw & ~CW_FSEL);
        end
      end
      OP_PHASE:   op_fail = reg_eff[1];
      OP_PSEL: begin
        op_fail = reg_eff[1];
        if (!reg_eff[1]) begin
          cw_new = reg_eff[0] ? (cw | CW_PSEL) : (cw & ~CW_PSEL);
        end
      end
      OP_SLEEP:   cw_new = sl_q ? (cw | CW_SLEEP) : (cw & ~CW_SLEEP);
    endcase
  end

  always_comb begin
    div_req.start    = (state == S_EXEC) && !op_fail &&
                       ((cur_op == OP_FREQ) || (cur_op == OP_PHASE));
    div_req.dividend = (cur_op == OP_FREQ) ? freq_num : DIV_NW'(phase_num);
    div_req.divisor  = (cur_op == OP_FREQ) ? {mclk, 1'b0} : PHASE_DIV;
  end

  always_comb begin
    res_valid       = 1'b0;
    res.chip_select = ch_q;
    res.spi_word    = '0;
    res.word_valid  = 1'b0;
    res.status      = 1'b0;
    res.last        = 1'b0;
    unique case (state)
      S_TX_INIT, S_TX_FCW: begin
        res_valid      = 1'b1;
        res.spi_word   = cw;
        res.word_valid = 1'b1;
      end
      S_TX_CW: begin
        res_valid      = 1'b1;
        res.spi_word   = cw;
        res.word_valid = 1'b1;
        res.last       = is_last;
      end
      S_TX_FLO: begin
        res_valid      = !div_busy;
        res.spi_word   = base_f | {2'b00, div_quot[13:0]};
        res.word_valid = 1'b1;
      end
      S_TX_FHI: begin
        res_valid      = 1'b1;
        res.spi_word   = base_f | {2'b00, div_quot[27:14]};
        res.word_valid = 1'b1;
        res.last       = is_last;
      end
      S_TX_PH: begin
        res_valid      = !div_busy;
        res.spi_word   = base_p | {4'd0, div_quot[11:0]};
        res.word_valid = 1'b1;
        res.last       = is_last;
      end
      S_TX_NOP: begin
        res_valid = 1'b1;
        res.last  = 1'b1;
      end
      S_ERR: begin
        res_valid  = 1'b1;
        res.status = 1'b1;
        res.last   = 1'b1;
      end
      S_IDLE, S_PREP, S_EXEC: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= '0;
      pc    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_q <= action;
            ch_q  <= channel;
            reg_q <= reg_select;
            fq_q  <= frequency_q8;
            ph_q  <= ph_red;
            wf_q  <= waveform;
            sl_q  <= sleep_enable;
            pc    <= '0;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (cmd_bad) begin
            state <= S_ERR;
          end else if (act_q != ACT_INIT && act_q != ACT_STOP && !ready[ch_idx]) begin
            // auto-init before the command proper
            shadow[ch_idx] <= CW_INIT;
            ready[ch_idx]  <= 1'b1;
            state          <= S_TX_INIT;
          end else begin
            state <= S_EXEC;
          end
        end
        S_TX_INIT: begin
          if (take) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!(cur_op == OP_STOP && !ready[ch_idx])) begin
            shadow[ch_idx] <= cw_new;
          end
          if (cur_op == OP_INIT) begin
            ready[ch_idx] <= 1'b1;
          end
          if (op_fail) begin
            state <= S_ERR;
          end else if (cur_op == OP_FREQ) begin
            state <= S_TX_FCW;
          end else if (cur_op == OP_PHASE) begin
            state <= S_TX_PH;
          end else if (cur_op == OP_STOP && !ready[ch_idx]) begin
            state <= S_TX_NOP;
          end else begin
            state <= S_TX_CW;
          end
        end
        S_TX_FCW: begin
          if (take) begin
            state <= S_TX_FLO;
          end
        end
        S_TX_FLO: begin
          if (take) begin
            state <= S_TX_FHI;
          end
        end
        S_TX_CW, S_TX_FHI, S_TX_PH: begin
          if (take) begin
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              pc    <= pc + 1'b1;
              state <= S_EXEC;
            end
          end
        end
        S_TX_NOP, S_ERR: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ hdl/dds_serial_command_sequencer.sv @@
// Top level of the serial command sequencer: clock register, result register.
// Depends on dsc_pkg, dsc_ctrl, dsc_divider and the assertion macro header.
//
//  channel  | handshake             | content
//  ---------+-----------------------+------------------------------------------
//  cfg      | cfg_valid / cfg_ready | master_clock_hz
//  input    | in_valid / in_stall   | action, channel, reg_select, frequency_q8,
//           |                       | phase_centideg, waveform, sleep_enable
//  output   | out_valid / out_stall | chip_select, spi_word, word_valid, status, last
//
// A command is decoded in the prepare and execute states, then emits its words; set freq
// and set phase each make one pass of the shared serial divider, set wave makes two.
// The divider loop gives one quotient bit per cycle; the quotient words wait for it.
// Reset is synchronous: channels become uninitialized, the clock returns to
// 25 MHz. A stalled output holds the sequencer at its current word.
`include "dds_serial_command_sequencer_macros.svh"

module dds_serial_command_sequencer import dsc_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [MCLK_W-1:0]  master_clock_hz,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         action,
  input  logic               channel,
  input  logic [1:0]         reg_select,
  input  logic [FREQ_W-1:0]  frequency_q8,
  input  logic [PHASE_W-1:0] phase_centideg,
  input  logic [1:0]         waveform,
  input  logic               sleep_enable,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               chip_select,
  output logic [WORD_W-1:0]  spi_word,
  output logic               word_valid,
  output logic               status,
  output logic               last
);

  logic [MCLK_W-1:0] mclk;
  div_req_t          div_req;
  logic              div_busy;
  logic [DIV_QW-1:0] div_quot;
  logic              res_valid;
  res_t              res;
  logic              res_ready;
  res_t              out_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mclk <= MCLK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mclk <= master_clock_hz;
    end
  end

  dsc_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .channel        (channel),
    .reg_select     (reg_select),
    .frequency_q8   (frequency_q8),
    .phase_centideg (phase_centideg),
    .waveform       (waveform),
    .sleep_enable   (sleep_enable),
    .mclk           (mclk),
    .div_req        (div_req),
    .div_busy       (div_busy),
    .div_quot       (div_quot),
    .res_valid      (res_valid),
    .res            (res),
    .res_ready      (res_ready)
  );

  dsc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // Output register: load when empty or when the held word leaves
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign chip_select = out_q.chip_select;
  assign spi_word    = out_q.spi_word;
  assign word_valid  = out_q.word_valid;
  assign status      = out_q.status;
  assign last        = out_q.last;

  `DSC_ASSERT(a_err_is_last, !(out_valid && status) || last, "error result not marked last")
  `DSC_ASSERT(a_nop_no_word, !(out_valid && !word_valid) || (spi_word == '0), "status-only result carries a word")
  `DSC_ASSERT(a_busy_stall, !(out_valid && !last) || in_stall, "input open while a command is still running")
  `DSC_ASSERT_NEXT(a_accept_stall, in_valid && !in_stall, in_stall, "no stall after an accepted request")

endmodule
